// ----- design/mba_pkg.sv -----
// Shared types, constants and helpers for the mosaic block averager.
// No dependencies; imported by mba_div, mba_merge, mosaic_block_average and mba_checker.
`default_nettype none
package mba_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_BLOCK  = 32;

  localparam int POS_W   = 12;  // pixel/block position
  localparam int DIM_W   = 13;  // frame size registers
  localparam int BS_W    = 6;   // block size register
  localparam int SUB_W   = 5;   // position inside a block
  localparam int CH_W    = 8;
  localparam int BSUM_W  = 18;
  localparam int FSUM_W  = 32;
  localparam int NUM_W   = 32;  // divider dividend / quotient
  localparam int DEN_W   = 25;  // divider divisor / remainder
  localparam int CNT_W   = 6;
  localparam int LANES   = 3;
  localparam int ENTRY_W = 3 * BSUM_W;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] block_row;
    logic [POS_W-1:0] block_col;
    logic [CH_W-1:0]  red_avg;
    logic [CH_W-1:0]  green_avg;
    logic [CH_W-1:0]  blue_avg;
    logic             last;
  } out_t;

  // header fields handed to the merge stage along with the lane quotients
  typedef struct packed {
    logic             load;
    logic             kind;
    logic [POS_W-1:0] block_row;
    logic [POS_W-1:0] block_col;
    logic             last;
  } mrg_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [BS_W-1:0] clamp_bs(input logic [BS_W-1:0] v);
    logic [BS_W-1:0] r;
    r = v;
    if (v == '0) r = BS_W'(1);
    else if (v > BS_W'(MAX_BLOCK)) r = BS_W'(MAX_BLOCK);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/mba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/mba_div.sv -----
// One divider lane: restoring division, one quotient bit per cycle.
// Depends on mba_pkg.
`default_nettype none
module mba_div import mba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo,
  output logic      [DEN_W-1:0] rem
);
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    rem_nxt = trial[DEN_W-1:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = DEN_W'(trial - {1'b0, den_r});
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ----- design/mba_merge.sv -----
// Merge stage: saturates the three lane quotients into one result beat
// and holds it in the output register. Depends on mba_pkg.
`default_nettype none
module mba_merge import mba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrg_ctl_t         ctl,
  input  wire logic [NUM_W-1:0] quo [LANES],
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data
);
  logic [CH_W-1:0] sat [LANES];
  logic            valid_r;
  out_t            data_r;

  // averages above full scale clip
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sat[i] = (quo[i][NUM_W-1:CH_W] != '0) ? {CH_W{1'b1}} : quo[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (ctl.load) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r.kind      <= ctl.kind;
      data_r.block_row <= ctl.block_row;
      data_r.block_col <= ctl.block_col;
      data_r.red_avg   <= sat[0];
      data_r.green_avg <= sat[1];
      data_r.blue_avg  <= sat[2];
      data_r.last      <= ctl.last;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule
`default_nettype wire

// ----- design/mosaic_block_average.sv -----
// One pixel is in flight at a time: the next pixel is taken only after
// the result beats of the previous one, if any, have been taken. A block
// average beat follows the column sum read, the bit-serial divider lanes
// and the merge register; the frame average is divided once the block
// beat is taken. After a configuration write, the lanes realign the block
// counters. Reset: synchronous, active low; state cleared, frame size set
// to 640 x 480 and block size to 8. Top level of the mosaic block averager;
// depends on mba_pkg, mba_ram, mba_div and mba_merge.
`default_nettype none
module mosaic_block_average import mba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_wdata
);
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SYNC = 8'b0000_0010,
    ST_READ = 8'b0000_0100,
    ST_DIVB = 8'b0000_1000,
    ST_OUTB = 8'b0001_0000,
    ST_DIVF = 8'b0010_0000,
    ST_OUTF = 8'b0100_0000,
    ST_WAIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] fw_r, fh_r, w_cl, h_cl;
  logic [BS_W-1:0]  bs_r, bs_cl;
  logic [SUB_W-1:0] bs_m1;
  logic             sync_pend_r;

  logic [POS_W-1:0] col_r, row_r, bc_r, br_r;
  logic [SUB_W-1:0] cin_r, rin_r;

  // captured per pixel
  in_t              pix_r;
  logic [POS_W-1:0] cur_bc_r, cur_br_r;
  logic [SUB_W-1:0] cur_cin_r, cur_rin_r;
  logic             first_r, emit_r, fend_r;

  logic [FSUM_W-1:0] fsum_r [LANES];
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [BSUM_W-1:0]  bsum [LANES];
  logic [CH_W-1:0]    pch [LANES];
  logic [11:0]        area;

  logic             accept, last_col, last_row, cin_end, rin_end;
  logic             div_start;
  logic [NUM_W-1:0] div_num [LANES];
  logic [DEN_W-1:0] div_den [LANES];
  logic [NUM_W-1:0] quo [LANES];
  logic [DEN_W-1:0] rem [LANES];
  logic [LANES-1:0] done;
  mrg_ctl_t         mctl;

  assign w_cl  = clamp_dim(fw_r, DIM_W'(MAX_WIDTH));
  assign h_cl  = clamp_dim(fh_r, DIM_W'(MAX_HEIGHT));
  assign bs_cl = clamp_bs(bs_r);
  assign bs_m1 = SUB_W'(bs_cl - BS_W'(1));

  assign in_ready = (state_r == ST_IDLE) && !sync_pend_r;
  assign accept   = in_valid && in_ready;
  assign last_col = ({1'b0, col_r} + DIM_W'(1)) >= w_cl;
  assign last_row = ({1'b0, row_r} + DIM_W'(1)) >= h_cl;
  assign cin_end  = cin_r == bs_m1;
  assign rin_end  = rin_r == bs_m1;

  // configuration registers; a write during realignment requests another pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= DIM_W'(640);
      fh_r        <= DIM_W'(480);
      bs_r        <= BS_W'(8);
      sync_pend_r <= 1'b0;
    end else begin
      if (state_r == ST_IDLE) sync_pend_r <= 1'b0;
      if (cfg_we) begin
        sync_pend_r <= 1'b1;
        unique case (cfg_index)
          REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
          REG_BLOCK_SIZE:   bs_r <= cfg_wdata[BS_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  // column sum store: one entry per block column
  mba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (state_r == ST_READ),
    .waddr (cur_bc_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (bc_r),
    .rdata (rdata)
  );

  // running block sums for this pixel
  always_comb begin
    pch[0] = pix_r.red_in;
    pch[1] = pix_r.green_in;
    pch[2] = pix_r.blue_in;
    for (int i = 0; i < LANES; i++) begin
      if (first_r) bsum[i] = BSUM_W'(pch[i]);
      else bsum[i] = rdata[i*BSUM_W +: BSUM_W] + BSUM_W'(pch[i]);
    end
    wdata = {bsum[2], bsum[1], bsum[0]};
    area  = 12'({1'b0, cur_rin_r} + 6'd1) * 12'({1'b0, cur_cin_r} + 6'd1);
  end

  // lane operands per phase
  always_comb begin
    div_start = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      div_num[i] = NUM_W'(bsum[i]);
      div_den[i] = DEN_W'(area);
    end
    if (state_r == ST_IDLE && sync_pend_r) begin
      div_start  = 1'b1;
      div_num[0] = NUM_W'(col_r);
      div_num[1] = NUM_W'(row_r);
      div_num[2] = '0;
      for (int i = 0; i < LANES; i++) div_den[i] = DEN_W'(bs_cl);
    end else if (state_r == ST_READ) begin
      div_start = emit_r;
    end else if (state_r == ST_OUTB && out_ready && fend_r) begin
      div_start = 1'b1;
      for (int i = 0; i < LANES; i++) begin
        div_num[i] = fsum_r[i];
        div_den[i] = DEN_W'(w_cl) * DEN_W'(h_cl);
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mba_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .done  (done[g]),
      .quo   (quo[g]),
      .rem   (rem[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (sync_pend_r) state_nxt = ST_SYNC;
               else if (accept) state_nxt = ST_READ;
      ST_SYNC: if (done[0]) state_nxt = ST_IDLE;
      ST_READ: state_nxt = emit_r ? ST_DIVB : ST_IDLE;
      ST_DIVB: if (done[0]) state_nxt = ST_OUTB;
      ST_OUTB: if (out_ready) state_nxt = fend_r ? ST_DIVF : ST_WAIT;
      ST_DIVF: if (done[0]) state_nxt = ST_OUTF;
      ST_OUTF: if (out_ready) state_nxt = ST_WAIT;
      ST_WAIT: if (!out_valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mctl.load      = done[0] && (state_r == ST_DIVB || state_r == ST_DIVF);
    mctl.kind      = (state_r == ST_DIVF) ? KIND_FRAME : KIND_BLOCK;
    mctl.block_row = (state_r == ST_DIVF) ? '0 : cur_br_r;
    mctl.block_col = (state_r == ST_DIVF) ? '0 : cur_bc_r;
    mctl.last      = (state_r == ST_DIVF) || !fend_r;
  end

  mba_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mctl),
    .quo       (quo),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // position counters and frame sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      bc_r    <= '0;
      br_r    <= '0;
      cin_r   <= '0;
      rin_r   <= '0;
      for (int i = 0; i < LANES; i++) fsum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SYNC && done[0]) begin
        bc_r  <= quo[0][POS_W-1:0];
        cin_r <= rem[0][SUB_W-1:0];
        br_r  <= quo[1][POS_W-1:0];
        rin_r <= rem[1][SUB_W-1:0];
      end
      if (accept) begin
        if (last_col) begin
          col_r <= '0;
          cin_r <= '0;
          bc_r  <= '0;
          if (last_row) begin
            row_r <= '0;
            rin_r <= '0;
            br_r  <= '0;
          end else begin
            row_r <= row_r + POS_W'(1);
            rin_r <= rin_end ? '0 : rin_r + SUB_W'(1);
            if (rin_end) br_r <= br_r + POS_W'(1);
          end
        end else begin
          col_r <= col_r + POS_W'(1);
          cin_r <= cin_end ? '0 : cin_r + SUB_W'(1);
          if (cin_end) bc_r <= bc_r + POS_W'(1);
        end
      end
      if (state_r == ST_READ) begin
        for (int i = 0; i < LANES; i++) fsum_r[i] <= fsum_r[i] + FSUM_W'(pch[i]);
      end
      if (div_start && state_r == ST_OUTB) begin
        for (int i = 0; i < LANES; i++) fsum_r[i] <= '0;
      end
    end
  end

  // per-pixel capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r     <= in_data;
      cur_bc_r  <= bc_r;
      cur_br_r  <= br_r;
      cur_cin_r <= cin_r;
      cur_rin_r <= rin_r;
      first_r   <= (cin_r == '0) && (rin_r == '0);
      emit_r    <= (cin_end || last_col) && (rin_end || last_row);
      fend_r    <= last_col && last_row;
    end
  end
endmodule
`default_nettype wire

// ----- design/mba_checker.sv -----
// Port-level checks for mosaic_block_average, bound to the top level.
// Depends on mba_pkg.
`default_nettype none
module mba_checker import mba_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one pixel in flight: no pixel right after a pixel
  a_one_pix: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous still in flight");

  // frame beat always closes the pixel's results
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_FRAME |-> out_data.last)
    else $error("frame average without last");

  // frame beat carries zero block position
  a_frame_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_FRAME |->
      out_data.block_row == '0 && out_data.block_col == '0)
    else $error("frame average with nonzero block position");
endmodule

bind mosaic_block_average mba_checker u_mba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/mosaic_block_average_test.sv -----
// Self-checking testbench for mosaic_block_average: streams frames of random,
// all-ones or all-zeros pixels, predicts block and frame averages in a
// scoreboard class. Depends on mba_pkg and the mosaic_block_average RTL.
module mosaic_block_average_test;
  import mba_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 80;

  // Predicts block/frame averages and checks the result beats in order
  class avg_scoreboard;
    bit [DIM_W-1:0] width_reg  = 640;
    bit [DIM_W-1:0] height_reg = 480;
    bit [BS_W-1:0]  bsize_reg  = 8;
    bit [ENTRY_W-1:0] col_sums [MAX_WIDTH];
    int unsigned col_pos, row_pos;
    bit [FSUM_W-1:0] fr_sum, fg_sum, fb_sum;
    out_t avg_q[$];
    int errors, block_beats, frame_beats;

    function void write_reg(logic [1:0] idx, logic [DIM_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = v;
        REG_FRAME_HEIGHT: height_reg = v;
        REG_BLOCK_SIZE:   bsize_reg  = v[BS_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [CH_W-1:0] mean8(longint unsigned s, longint unsigned a);
      longint unsigned q;
      q = s / a;
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function void note_pixel(in_t p);
      int unsigned w, h, bs, bc, br, cin, rin, idx;
      bit last_c, last_r;
      bit [BSUM_W-1:0] sr, sg, sb;
      bit [ENTRY_W-1:0] e;
      out_t o;
      w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h  = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      bs = (bsize_reg == 0) ? 1 : (bsize_reg > MAX_BLOCK) ? MAX_BLOCK : bsize_reg;
      last_c = col_pos + 1 >= w;
      last_r = row_pos + 1 >= h;
      bc = col_pos / bs; br = row_pos / bs;
      cin = col_pos % bs; rin = row_pos % bs;
      idx = bc % MAX_WIDTH;
      // top-left pixel of a block restarts the column sums
      if (cin == 0 && rin == 0) begin
        sr = p.red_in; sg = p.green_in; sb = p.blue_in;
      end else begin
        e  = col_sums[idx];
        sr = e[17:0] + p.red_in;
        sg = e[35:18] + p.green_in;
        sb = e[53:36] + p.blue_in;
      end
      col_sums[idx] = {sb, sg, sr};
      fr_sum += p.red_in; fg_sum += p.green_in; fb_sum += p.blue_in;
      if ((cin == bs - 1 || last_c) && (rin == bs - 1 || last_r)) begin
        o.kind      = KIND_BLOCK;
        o.block_row = br[POS_W-1:0];
        o.block_col = bc[POS_W-1:0];
        o.red_avg   = mean8(sr, (rin + 1) * (cin + 1));
        o.green_avg = mean8(sg, (rin + 1) * (cin + 1));
        o.blue_avg  = mean8(sb, (rin + 1) * (cin + 1));
        o.last      = !(last_c && last_r);
        avg_q.push_back(o);
        if (last_c && last_r) begin
          o.kind      = KIND_FRAME;
          o.block_row = '0;
          o.block_col = '0;
          o.red_avg   = mean8(fr_sum, longint'(w) * h);
          o.green_avg = mean8(fg_sum, longint'(w) * h);
          o.blue_avg  = mean8(fb_sum, longint'(w) * h);
          o.last      = 1'b1;
          avg_q.push_back(o);
        end
      end
      // advance raster position
      if (last_c) begin
        col_pos = 0;
        if (last_r) begin
          row_pos = 0;
          fr_sum = '0; fg_sum = '0; fb_sum = '0;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void cmp(string field, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_o;
      if (avg_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %p", $time, got);
        return;
      end
      exp_o = avg_q.pop_front();
      if (got.kind == KIND_FRAME) frame_beats++; else block_beats++;
      cmp("kind", exp_o.kind, got.kind);
      cmp("block_row", exp_o.block_row, got.block_row);
      cmp("block_col", exp_o.block_col, got.block_col);
      cmp("red_avg", exp_o.red_avg, got.red_avg);
      cmp("green_avg", exp_o.green_avg, got.green_avg);
      cmp("blue_avg", exp_o.blue_avg, got.blue_avg);
      cmp("last", exp_o.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  avg_scoreboard sb = new();
  int idle_pct, stall_pct;
  int idle_cycles;
  int pixels_sent, frames_sent;

  mosaic_block_average u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // result side: check beats, random backpressure, watchdog
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= stall_pct);
    if ((out_valid && out_ready) || (in_valid && in_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_pixel(in_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // drain everything, then write all three registers back to back
  task automatic write_regs(bit [DIM_W-1:0] w, bit [DIM_W-1:0] h, bit [DIM_W-1:0] bs);
    in_valid <= 1'b0;
    while (sb.avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_FRAME_WIDTH; cfg_wdata <= w;
    sb.write_reg(REG_FRAME_WIDTH, w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT; cfg_wdata <= h;
    sb.write_reg(REG_FRAME_HEIGHT, h);
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE; cfg_wdata <= bs;
    sb.write_reg(REG_BLOCK_SIZE, bs);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_t pick_pixel(int mode);
    in_t p;
    case (mode)
      1: p = '1;
      2: p = '0;
      default: p = in_t'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_pixels(int n, int mode);
    repeat (n) send_pixel(pick_pixel(mode));
  endtask

  // one complete frame at the given register values
  task automatic run_frame(bit [DIM_W-1:0] w, bit [DIM_W-1:0] h, bit [DIM_W-1:0] bs,
                           int mode);
    int cw, ch;
    cw = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    ch = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    write_regs(w, h, bs);
    send_pixels(cw * ch, mode);
    frames_sent++;
  endtask

  initial begin
    int start;
    idle_pct = 0; stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single pixel, clamped registers, partial blocks, extremes
    run_frame(1, 1, 1, 0);
    run_frame(0, 0, 0, 1);
    run_frame(3, 2, 2, 2);
    run_frame(5, 3, 63, 1);
    // height cut to one at the start of the third row, the first row of a band
    write_regs(4, 4, 2);
    send_pixels(8, 0);
    write_regs(4, 1, 2);
    send_pixels(4, 0);
    frames_sent++;

    // random frames over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      start = pixels_sent;
      while (pixels_sent - start < 230) begin
        if ($urandom_range(9) == 0)
          run_frame($urandom_range(40), $urandom_range(6), $urandom_range(63), 0);
        else
          run_frame($urandom_range(1, 16), $urandom_range(1, 12),
                    $urandom_range(1, 8), 0);
      end
    end

    in_valid <= 1'b0;
    while (sb.avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d pixels in %0d frames; checked %0d block and %0d frame averages.",
             pixels_sent, frames_sent, sb.block_beats, sb.frame_beats);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mba_pkg.sv
design/mba_ram.sv
design/mba_div.sv
design/mba_merge.sv
design/mosaic_block_average.sv
design/mba_checker.sv
tb/mosaic_block_average_test.sv
